// ----- rtl/core/hpmix_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpmix_pkg
// Shared widths, limits, reset values and register indexes of the heading
// PID controller with its four-motor mixer.
// ----------------------------------------------------------------------------
package hpmix_pkg;

    // Field widths
    localparam int ANGLE_W   = 24;
    localparam int TARGET_W  = 16;
    localparam int BASE_W    = 8;
    localparam int GAIN_W    = 24;
    localparam int ERR_W     = 16;
    localparam int SUM_W     = 8;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Guard bits kept below the sample's own fraction in the smoothed angle.
    localparam int EMA_GUARD = 16;
    localparam int SMOOTH_W  = ANGLE_W + EMA_GUARD;

    // Correction and duties are Q.16 inside the mixer.
    localparam int MIX_FRAC  = 16;

    localparam int ERR_LIMIT = 32767;
    localparam int DUTY_MAX  = 255;
    localparam int EMA_DIV   = 10;

    // Defaults of the top-level parameters
    localparam int DEF_ANGLE_FRAC_BITS = 8;
    localparam int DEF_SUM_LIMIT       = 100;

    // Register reset values
    localparam logic signed [TARGET_W-1:0] RST_TARGET = '0;
    localparam logic [BASE_W-1:0] RST_BASE   = 8'd120;
    localparam logic [GAIN_W-1:0] RST_GAIN_P = 24'd720896;
    localparam logic [GAIN_W-1:0] RST_GAIN_I = 24'd655;
    localparam logic [GAIN_W-1:0] RST_GAIN_D = 24'd360448;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd4;

endpackage

// ----- rtl/core/heading_pid_four_motor_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_four_motor_mixer
// Smooths a heading sample, runs a clamped PID on the heading error and
// mixes the correction into four motor duties.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         angle_sample
//  m_axis    out        four duties and the saturated heading error
//  cfg       in         target, base duty and the three gains
//
//  An accepted word runs through the divide by ten of the smoothing filter,
//  in four steps of twelve quotient bits each by reciprocal multiply, then
//  through the shared 25 x 18 multiplier that forms the three PID products,
//  and on to the result register. Reset is synchronous and active low; it
//  clears the filter, integral and previous error and loads the register
//  defaults. s_axis_tready is high only while no word is in work. A finished
//  result waits in the output register, and a new word may be accepted
//  meanwhile; it stalls only at the final step if that result has still not
//  been taken.
// ----------------------------------------------------------------------------
module heading_pid_four_motor_mixer #(
    parameter int ANGLE_FRAC_BITS = hpmix_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int SUM_LIMIT       = hpmix_pkg::DEF_SUM_LIMIT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] angle_sample

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] duty_front_left, [15:8] duty_front_right, [23:16] duty_back_left,
    // [31:24] duty_back_right, [47:32] heading_error
    output logic [47:0] m_axis_tdata,

    input  logic        cfg_we,
    input  logic [hpmix_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hpmix_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int SW  = hpmix_pkg::SMOOTH_W;
    // Numerator of the filter: 9*s plus the widened sample, with sign.
    localparam int NW  = SW + 5;
    localparam int MW  = NW - 1;
    // Long division by ten, one chunk of quotient bits per cycle. Every step
    // divides a value below ten times 2^DIV_CHUNK, which the reciprocal
    // multiply below handles exactly for 16-bit values.
    localparam int DIV_CHUNK = 12;
    localparam int DIV_STEPS = (MW + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int QPW = DIV_STEPS * DIV_CHUNK;
    localparam int RW  = 4;
    localparam int VW  = RW + DIV_CHUNK;
    localparam int RECIP_SH = 19;
    localparam logic [VW-1:0] RECIP =
        VW'(((1 << RECIP_SH) + hpmix_pkg::EMA_DIV - 1) / hpmix_pkg::EMA_DIV);
    localparam int CNT_W = $clog2(DIV_STEPS + 1);
    localparam int FS  = ANGLE_FRAC_BITS + hpmix_pkg::EMA_GUARD;
    localparam int TW  = hpmix_pkg::TARGET_W + FS;
    localparam int DW  = ((TW > SW) ? TW : SW) + 1;
    localparam int QW  = DW - FS;
    localparam int EW  = hpmix_pkg::ERR_W;
    localparam int DFW = EW + 1;
    localparam int MBW = DFW + 1;
    localparam int MAW = hpmix_pkg::GAIN_W + 1;
    localparam int PW  = MAW + MBW;
    localparam int AW  = PW + 2;
    localparam int CW  = hpmix_pkg::BASE_W + hpmix_pkg::MIX_FRAC + 1;
    localparam int XW  = CW + 1;

    localparam logic signed [QW-1:0]  Q_HI   = QW'(hpmix_pkg::ERR_LIMIT);
    localparam logic signed [QW-1:0]  Q_LO   = -QW'(hpmix_pkg::ERR_LIMIT);
    localparam logic signed [DFW-1:0] SUM_HI = DFW'(SUM_LIMIT);
    localparam logic signed [DFW-1:0] SUM_LO = -DFW'(SUM_LIMIT);
    localparam logic signed [XW-1:0]  DUTY_TOP =
        XW'(hpmix_pkg::DUTY_MAX) <<< hpmix_pkg::MIX_FRAC;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_DIVIDE, ST_STORE, ST_ERROR,
        ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_ACC, ST_CLAMP, ST_MIX
    } state_t;

    // Configuration registers
    logic signed [hpmix_pkg::TARGET_W-1:0] target_reg;
    logic [hpmix_pkg::BASE_W-1:0] base_reg;
    logic [hpmix_pkg::GAIN_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= hpmix_pkg::RST_TARGET;
            base_reg   <= hpmix_pkg::RST_BASE;
            gain_p_reg <= hpmix_pkg::RST_GAIN_P;
            gain_i_reg <= hpmix_pkg::RST_GAIN_I;
            gain_d_reg <= hpmix_pkg::RST_GAIN_D;
        end else if (cfg_we) begin
            case (cfg_index)
                hpmix_pkg::REG_TARGET: target_reg <= cfg_wdata[hpmix_pkg::TARGET_W-1:0];
                hpmix_pkg::REG_BASE:   base_reg   <= cfg_wdata[hpmix_pkg::BASE_W-1:0];
                hpmix_pkg::REG_GAIN_P: gain_p_reg <= cfg_wdata[hpmix_pkg::GAIN_W-1:0];
                hpmix_pkg::REG_GAIN_I: gain_i_reg <= cfg_wdata[hpmix_pkg::GAIN_W-1:0];
                hpmix_pkg::REG_GAIN_D: gain_d_reg <= cfg_wdata[hpmix_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    state_t state_reg;
    logic signed [SW-1:0] smooth_reg;
    logic signed [hpmix_pkg::SUM_W-1:0] sum_reg;
    logic signed [EW-1:0] last_err_reg;
    logic signed [EW-1:0] err_reg;
    logic signed [DFW-1:0] deriv_reg;
    logic signed [hpmix_pkg::ANGLE_W-1:0] sample_reg;
    logic [QPW-1:0] quo_reg;
    logic [RW-1:0] rem_reg;
    logic neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [CW-1:0] corr_reg;
    logic m_valid_reg;
    logic [47:0] m_data_reg;

    // Filter numerator: 9*s written as 8*s + s.
    logic signed [NW-1:0] s_ext, x_ext, ema_num;
    logic [MW-1:0] ema_mag;
    always_comb begin
        s_ext   = NW'(smooth_reg);
        x_ext   = NW'(sample_reg);
        ema_num = (s_ext <<< 3) + s_ext + (x_ext <<< hpmix_pkg::EMA_GUARD);
        ema_mag = ema_num[NW-1] ? MW'(-ema_num) : ema_num[MW-1:0];
    end

    // One step of the divide by ten: remainder and next chunk of the magnitude.
    logic [VW-1:0] div_val;
    logic [2*VW-1:0] div_prod;
    logic [DIV_CHUNK-1:0] div_q;
    logic [VW-1:0] div_rem;
    always_comb begin
        div_val  = {rem_reg, quo_reg[QPW-1 -: DIV_CHUNK]};
        div_prod = div_val * RECIP;
        div_q    = div_prod[RECIP_SH +: DIV_CHUNK];
        div_rem  = div_val - VW'(div_q) * VW'(hpmix_pkg::EMA_DIV);
    end

    logic signed [SW-1:0] smooth_new;
    assign smooth_new = neg_reg ? -$signed(quo_reg[SW-1:0]) : $signed(quo_reg[SW-1:0]);

    // Error, truncated toward zero and saturated; integral and derivative.
    logic signed [DW-1:0] tgt_ext, diff;
    logic signed [QW-1:0] q_floor, q_trunc;
    logic signed [EW-1:0] err_new;
    logic signed [DFW-1:0] sum_raw, deriv_new;
    logic signed [hpmix_pkg::SUM_W-1:0] sum_new;
    always_comb begin
        tgt_ext = DW'(target_reg) <<< FS;
        diff    = tgt_ext - DW'(smooth_reg);
        q_floor = diff[DW-1:FS];
        q_trunc = q_floor + QW'(diff[DW-1] && (|diff[FS-1:0]));
        if (q_trunc > Q_HI) begin
            err_new = EW'(Q_HI);
        end else if (q_trunc < Q_LO) begin
            err_new = EW'(Q_LO);
        end else begin
            err_new = q_trunc[EW-1:0];
        end
        sum_raw = DFW'(sum_reg) + DFW'(err_new);
        if (sum_raw > SUM_HI) begin
            sum_new = hpmix_pkg::SUM_W'(SUM_HI);
        end else if (sum_raw < SUM_LO) begin
            sum_new = hpmix_pkg::SUM_W'(SUM_LO);
        end else begin
            sum_new = sum_raw[hpmix_pkg::SUM_W-1:0];
        end
        deriv_new = DFW'(err_new) - DFW'(last_err_reg);
    end

    // The shared multiplier: one gain times one PID term per cycle.
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;
    always_comb begin
        case (state_reg)
            ST_MUL_I: begin
                mul_a = $signed({1'b0, gain_i_reg});
                mul_b = MBW'(sum_reg);
            end
            ST_MUL_D: begin
                mul_a = $signed({1'b0, gain_d_reg});
                mul_b = MBW'(deriv_reg);
            end
            default: begin
                mul_a = $signed({1'b0, gain_p_reg});
                mul_b = MBW'(err_reg);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Correction limit and duty mix.
    logic signed [AW-1:0] limit_a;
    logic signed [CW-1:0] corr_new;
    logic signed [XW-1:0] base_q, duty_plus_q, duty_minus_q;
    logic [hpmix_pkg::DUTY_W-1:0] duty_plus, duty_minus, duty_left, duty_right;

    function automatic logic [hpmix_pkg::DUTY_W-1:0] duty_sat(
        input logic signed [XW-1:0] v
    );
        logic [hpmix_pkg::DUTY_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > DUTY_TOP) begin
            r = hpmix_pkg::DUTY_W'(hpmix_pkg::DUTY_MAX);
        end else begin
            r = v[hpmix_pkg::MIX_FRAC +: hpmix_pkg::DUTY_W];
        end
        return r;
    endfunction

    always_comb begin
        limit_a = AW'({base_reg, {hpmix_pkg::MIX_FRAC{1'b0}}});
        if (acc_reg > limit_a) begin
            corr_new = CW'(limit_a);
        end else if (acc_reg < -limit_a) begin
            corr_new = CW'(-limit_a);
        end else begin
            corr_new = acc_reg[CW-1:0];
        end
        base_q       = XW'({base_reg, {hpmix_pkg::MIX_FRAC{1'b0}}});
        duty_plus_q  = base_q + XW'(corr_reg);
        duty_minus_q = base_q - XW'(corr_reg);
        duty_plus    = duty_sat(duty_plus_q);
        duty_minus   = duty_sat(duty_minus_q);
        // A positive error steers with the left pair; otherwise with the right.
        duty_left    = (err_reg > 0) ? duty_plus  : duty_minus;
        duty_right   = (err_reg > 0) ? duty_minus : duty_plus;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            smooth_reg   <= '0;
            sum_reg      <= '0;
            last_err_reg <= '0;
            m_valid_reg  <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            // The final step reloads the output register itself.
            if (m_valid_reg && m_axis_tready && state_reg != ST_MIX) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        sample_reg <= s_axis_tdata;
                        state_reg  <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    quo_reg   <= QPW'(ema_mag);
                    rem_reg   <= '0;
                    neg_reg   <= ema_num[NW-1];
                    cnt_reg   <= '0;
                    state_reg <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    quo_reg <= {quo_reg[QPW-DIV_CHUNK-1:0], div_q};
                    rem_reg <= div_rem[RW-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE: begin
                    smooth_reg <= smooth_new;
                    state_reg  <= ST_ERROR;
                end
                ST_ERROR: begin
                    err_reg      <= err_new;
                    sum_reg      <= sum_new;
                    deriv_reg    <= deriv_new;
                    last_err_reg <= err_new;
                    state_reg    <= ST_MUL_P;
                end
                ST_MUL_P: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_I;
                end
                ST_MUL_I: begin
                    acc_reg   <= AW'(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D: begin
                    acc_reg   <= acc_reg + AW'(prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg   <= acc_reg + AW'(prod_reg);
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    corr_reg  <= corr_new;
                    state_reg <= ST_MIX;
                end
                ST_MIX: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_data_reg  <= {err_reg, duty_right, duty_left,
                                        duty_right, duty_left};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heading PID controller and its four-motor
// mixer. A scoreboard keeps its own filter, integral and previous-error
// state, predicts the duties and the saturated error of every accepted
// sample, and compares each result word field by field. Directed phases
// cover the reset settings, the field and register extremes, error
// saturation, both mixer directions and a zero base duty. Random phases
// follow, with fresh register settings and random idling on both streams.
// ----------------------------------------------------------------------------

class heading_mixer_scoreboard;

    typedef struct packed {
        logic signed [15:0] heading_error;
        logic [7:0]         back_right;
        logic [7:0]         back_left;
        logic [7:0]         front_right;
        logic [7:0]         front_left;
    } duty_word_t;

    localparam int  FRAC_BITS = hpmix_pkg::DEF_ANGLE_FRAC_BITS;
    localparam int  SUM_CLAMP = hpmix_pkg::DEF_SUM_LIMIT;
    localparam int  GUARD     = hpmix_pkg::EMA_GUARD;
    localparam int  MIX_FRAC  = hpmix_pkg::MIX_FRAC;

    // Register copies
    logic signed [hpmix_pkg::TARGET_W-1:0] target_deg;
    logic [hpmix_pkg::BASE_W-1:0]          base_duty;
    logic [hpmix_pkg::GAIN_W-1:0]          gain_p;
    logic [hpmix_pkg::GAIN_W-1:0]          gain_i;
    logic [hpmix_pkg::GAIN_W-1:0]          gain_d;

    // Controller state
    longint filt_angle;
    longint err_sum;
    longint prev_err;

    duty_word_t expected_words[$];
    int         mismatches;
    int         words_checked;
    int         samples_noted;

    function new();
        target_deg    = hpmix_pkg::RST_TARGET;
        base_duty     = hpmix_pkg::RST_BASE;
        gain_p        = hpmix_pkg::RST_GAIN_P;
        gain_i        = hpmix_pkg::RST_GAIN_I;
        gain_d        = hpmix_pkg::RST_GAIN_D;
        filt_angle    = 0;
        err_sum       = 0;
        prev_err      = 0;
        mismatches    = 0;
        words_checked = 0;
        samples_noted = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function void apply_register(logic [hpmix_pkg::CFG_IDX_W-1:0] idx,
                                 logic [hpmix_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            hpmix_pkg::REG_TARGET: target_deg = val[hpmix_pkg::TARGET_W-1:0];
            hpmix_pkg::REG_BASE:   base_duty  = val[hpmix_pkg::BASE_W-1:0];
            hpmix_pkg::REG_GAIN_P: gain_p     = val;
            hpmix_pkg::REG_GAIN_I: gain_i     = val;
            hpmix_pkg::REG_GAIN_D: gain_d     = val;
            default: ;
        endcase
    endfunction

    function void note_sample(logic [hpmix_pkg::ANGLE_W-1:0] raw);
        longint     x, one, err, sum, deriv, corr, lim, plus, minus;
        logic [7:0] left, right;
        duty_word_t w;
        x   = longint'($signed(raw));
        one = longint'(1) <<< (FRAC_BITS + GUARD);
        filt_angle = (9 * filt_angle + x * (longint'(1) <<< GUARD)) / 10;
        err = clamp((longint'(target_deg) * one - filt_angle) / one,
                    -hpmix_pkg::ERR_LIMIT, hpmix_pkg::ERR_LIMIT);
        sum = clamp(err_sum + err, -SUM_CLAMP, SUM_CLAMP);
        err_sum = sum;
        deriv = err - prev_err;
        corr = longint'(gain_p) * err + longint'(gain_i) * sum + longint'(gain_d) * deriv;
        lim  = longint'(base_duty) <<< MIX_FRAC;
        corr = clamp(corr, -lim, lim);
        plus  = clamp(lim + corr, 0, longint'(hpmix_pkg::DUTY_MAX) <<< MIX_FRAC);
        minus = clamp(lim - corr, 0, longint'(hpmix_pkg::DUTY_MAX) <<< MIX_FRAC);
        // A positive error speeds up the left side; zero or negative the right.
        if (err > 0) begin
            left  = 8'(plus >>> MIX_FRAC);
            right = 8'(minus >>> MIX_FRAC);
        end else begin
            left  = 8'(minus >>> MIX_FRAC);
            right = 8'(plus >>> MIX_FRAC);
        end
        prev_err = err;
        w.front_left    = left;
        w.front_right   = right;
        w.back_left     = left;
        w.back_right    = right;
        w.heading_error = 16'(err);
        expected_words.push_back(w);
        samples_noted++;
    endfunction

    function void check_word(logic [47:0] data);
        duty_word_t got, exp_w;
        got = data;
        words_checked++;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result word %h arrived with nothing expected", $realtime, data);
            return;
        end
        exp_w = expected_words.pop_front();
        if (got.front_left !== exp_w.front_left || got.front_right !== exp_w.front_right ||
            got.back_left !== exp_w.back_left || got.back_right !== exp_w.back_right ||
            got.heading_error !== exp_w.heading_error) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: word %0d expected fl=%0d fr=%0d bl=%0d br=%0d err=%0d,",
                         $realtime, words_checked,
                         exp_w.front_left, exp_w.front_right, exp_w.back_left,
                         exp_w.back_right, exp_w.heading_error);
                $display("    got fl=%0d fr=%0d bl=%0d br=%0d err=%0d",
                         got.front_left, got.front_right, got.back_left,
                         got.back_right, got.heading_error);
            end
        end
    endfunction

endclass

module tb_top;

    localparam int RANDOM_SAMPLES = 1600;
    localparam int STALL_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        cfg_we;
    logic [hpmix_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hpmix_pkg::CFG_DATA_W-1:0] cfg_wdata;

    heading_mixer_scoreboard sb;

    int tx_gap_pct;
    int rx_stall_pct;
    int phase_count;
    int quiet_cycles;

    heading_pid_four_motor_mixer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("[heading_pid_four_motor_mixer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : result_ready
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold == 0) hold = pick_gap(rx_stall_pct);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [23:0] angle);
        int gap;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angle;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_sample(angle);
    endtask

    // Drops the input stream and waits for every outstanding result.
    task automatic finish_phase();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge aclk);
        phase_count++;
    endtask

    task automatic write_reg(input logic [hpmix_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hpmix_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.apply_register(idx, val);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_unused_reg();
        write_reg(hpmix_pkg::CFG_IDX_W'(hpmix_pkg::REG_GAIN_D + 1 + $urandom_range(2)),
                  24'($urandom));
    endtask

    function automatic logic [23:0] pick_gain(int max_whole);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(0, max_whole << 16));
        endcase
    endfunction

    task automatic new_settings();
        logic [15:0] tgt;
        logic [7:0]  base;
        case ($urandom_range(5))
            0:       tgt = 16'h8000;
            1:       tgt = 16'h7FFF;
            2:       tgt = 16'($urandom);
            default: tgt = 16'($signed($urandom_range(0, 720)) - 360);
        endcase
        case ($urandom_range(7))
            0:       base = 8'd0;
            1:       base = 8'd255;
            default: base = 8'($urandom);
        endcase
        // Upper data bits are junk and must be dropped by the narrow registers.
        if ($urandom_range(3) != 0) write_reg(hpmix_pkg::REG_TARGET, {8'($urandom), tgt});
        if ($urandom_range(3) != 0) write_reg(hpmix_pkg::REG_BASE, {16'($urandom), base});
        if ($urandom_range(3) != 0) write_reg(hpmix_pkg::REG_GAIN_P, pick_gain(20));
        if ($urandom_range(3) != 0) write_reg(hpmix_pkg::REG_GAIN_I, pick_gain(1));
        if ($urandom_range(3) != 0) write_reg(hpmix_pkg::REG_GAIN_D, pick_gain(10));
        if ($urandom_range(4) == 0) write_unused_reg();
    endtask

    // Samples cluster around the target so the controller leaves saturation.
    function automatic logic [23:0] pick_angle();
        int center, pick, offset;
        center = int'(sb.target_deg) * (1 << hpmix_pkg::DEF_ANGLE_FRAC_BITS);
        pick = $urandom_range(99);
        if (pick < 60) begin
            offset = $signed($urandom_range(0, 1 << $urandom_range(0, 14)));
            if ($urandom_range(1)) offset = -offset;
        end else if (pick < 80) begin
            offset = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        end else if (pick < 90) begin
            return 24'($urandom);
        end else begin
            return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
        end
        center += offset;
        if (center > 8388607) center = 8388607;
        if (center < -8388608) center = -8388608;
        return 24'(center);
    endfunction

    initial begin : main_flow
        int sent;
        int phase_len;
        sb = new();
        phase_count   = 0;
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings, sample extremes and small steps either way.
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'h000100);
        send_sample(24'hFFFF00);
        finish_phase();

        // Largest target and gains: the error saturates high.
        write_reg(hpmix_pkg::REG_TARGET, 24'hA57FFF);
        write_reg(hpmix_pkg::REG_BASE, 24'h3C00FF);
        write_reg(hpmix_pkg::REG_GAIN_P, 24'hFFFFFF);
        write_reg(hpmix_pkg::REG_GAIN_I, 24'hFFFFFF);
        write_reg(hpmix_pkg::REG_GAIN_D, 24'hFFFFFF);
        write_unused_reg();
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);
        finish_phase();

        // Lowest target with zero base duty: saturated low error, all duties off.
        write_reg(hpmix_pkg::REG_TARGET, 24'hFF8000);
        write_reg(hpmix_pkg::REG_BASE, 24'hFFFF00);
        write_reg(hpmix_pkg::REG_GAIN_P, 24'($urandom));
        send_sample(24'h7FFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
        finish_phase();

        // Zero gains leave every duty at the base.
        write_reg(hpmix_pkg::REG_TARGET, 24'h000000);
        write_reg(hpmix_pkg::REG_BASE, 24'h0000FF);
        write_reg(hpmix_pkg::REG_GAIN_P, 24'h000000);
        write_reg(hpmix_pkg::REG_GAIN_I, 24'h000000);
        write_reg(hpmix_pkg::REG_GAIN_D, 24'h000000);
        send_sample(24'h000000);
        send_sample(24'h000080);
        send_sample(24'hFFFF80);
        send_sample(24'h7FFFFF);
        finish_phase();

        sent = 0;
        while (sent < RANDOM_SAMPLES) begin
            new_settings();
            case ($urandom_range(3))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 30;
                default: tx_gap_pct = $urandom_range(0, 80);
            endcase
            case ($urandom_range(3))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 30;
                default: rx_stall_pct = $urandom_range(0, 80);
            endcase
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                send_sample(pick_angle());
                sent++;
            end
            finish_phase();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d samples in %0d phases of register settings with random idling.",
                 sb.samples_noted, phase_count);
        $display("Checked %0d result words, %0d mismatches.", sb.words_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("[heading_pid_four_motor_mixer] OK");
        end else begin
            $display("[heading_pid_four_motor_mixer] ERROR");
        end
        $finish;
    end

endmodule
